@@ sv/gbffa_pkg.sv @@
// Shared constants, types and codes for the grouped bitmap allocator.
`timescale 1ns / 1ps

package gbffa_pkg;

  localparam int MAX_GROUPS      = 8;
  localparam int MAX_GROUP_BITS  = 8192;
  localparam int WORDS_PER_GROUP = (MAX_GROUP_BITS + 31) / 32;
  localparam int GRP_W           = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WRD_W           = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
  localparam int ADDR_W          = GRP_W + WRD_W;
  localparam int ROWS            = 1 << ADDR_W;
  localparam int POS_W           = WRD_W + 5;

  localparam int NUM_W      = 17;
  localparam int GS_W       = 14;
  localparam int GC_W       = 4;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 14;

  localparam logic [GS_W-1:0] GS_RESET   = GS_W'(8192);
  localparam logic [GC_W-1:0] GC_RESET   = GC_W'(8);
  localparam logic            BASE_RESET = 1'b1;

  typedef logic [ST_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_SIZE  = 8'd0,
    CFG_GROUP_COUNT = 8'd1,
    CFG_NUMBER_BASE = 8'd2
  } cfg_idx_e;

endpackage

@@ sv/gbffa_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module gbffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/grouped_bitmap_first_fit_allocator.sv @@
// Grouped first-fit bitmap allocator: sequencer, word scanner and result register.
`timescale 1ns / 1ps

// The used/free bitmap sits in a 2048 x 32 RAM, one row per 32 bits of a group.
// After reset a clearing pass writes every row to zero, with the
// request input stalled; configuration writes are taken throughout.
// An allocate request reads and checks one bitmap word at a time, S_RD then
// S_CHK, through the single RAM read port, in group order; at the first word
// with a free bit it sets that bit, else it reports full once every group is
// scanned. A free request finds its group by repeated subtraction of the
// group size, one compare a cycle (up to 8), then reads the word and clears
// the bit if set; a number beyond the groups or below the base gets a range
// status. A held result register (out_stall_i) keeps a request waiting in
// S_RESP. Used count saturates at both bounds.
module grouped_bitmap_first_fit_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbffa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gbffa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [gbffa_pkg::NUM_W-1:0]       number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gbffa_pkg::NUM_W-1:0]       granted_o,
  output logic [gbffa_pkg::ST_W-1:0]        status_o,
  output logic [gbffa_pkg::NUM_W-1:0]       used_count_o
);

  import gbffa_pkg::*;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_FRD  = 8'b0010_0000,
    S_FCHK = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_e;

  function automatic logic [4:0] first_set(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [GS_W-1:0]   gs_q;
  logic [GC_W-1:0]   gc_q;
  logic              base_q;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [GRP_W-1:0]  g_q, g_d;
  logic [WRD_W-1:0]  w_q, w_d;
  logic [NUM_W-1:0]  acc_q, acc_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  used_q, used_d;
  logic [NUM_W-1:0]  res_granted_q, res_granted_d;
  status_t           res_status_q, res_status_d;

  logic              out_valid_q, out_valid_d;
  logic [NUM_W-1:0]  out_granted_q, out_granted_d;
  status_t           out_status_q, out_status_d;
  logic [NUM_W-1:0]  out_used_q, out_used_d;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [31:0]       wr_data, rd_data;

  logic [GS_W-1:0]   gs_eff;
  logic [GRP_W-1:0]  gc_last;
  logic [WRD_W-1:0]  last_w;
  logic [4:0]        tail;
  logic [31:0]       mask;
  logic [31:0]       freebits;
  logic [4:0]        fbit;
  logic [4:0]        rbit;
  logic [ADDR_W-1:0] scan_addr, free_addr;
  logic              in_acc, can_load;

  always_comb begin
    if (gs_q == '0) begin
      gs_eff = GS_W'(1);
    end else if (gs_q > GS_W'(MAX_GROUP_BITS)) begin
      gs_eff = GS_W'(MAX_GROUP_BITS);
    end else begin
      gs_eff = gs_q;
    end
    if (gc_q == '0) begin
      gc_last = '0;
    end else if (gc_q > GC_W'(MAX_GROUPS)) begin
      gc_last = GRP_W'(MAX_GROUPS - 1);
    end else begin
      gc_last = GRP_W'(gc_q - GC_W'(1));
    end
  end

  assign last_w    = WRD_W'((gs_eff - GS_W'(1)) >> 5);
  assign tail      = gs_eff[4:0];
  assign mask      = ((w_q == last_w) && (tail != '0)) ? ((32'h1 << tail) - 32'h1) : '1;
  assign freebits  = ~rd_data & mask;
  assign fbit      = first_set(freebits);
  assign rbit      = rem_q[4:0];
  assign scan_addr = {g_q, w_q};
  assign free_addr = {g_q, rem_q[POS_W-1:5]};

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign can_load    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q   <= GS_RESET;
      gc_q   <= GC_RESET;
      base_q <= BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GROUP_SIZE:  gs_q   <= cfg_data_i[GS_W-1:0];
        CFG_GROUP_COUNT: gc_q   <= cfg_data_i[GC_W-1:0];
        CFG_NUMBER_BASE: base_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    g_d           = g_q;
    w_d           = w_q;
    acc_d         = acc_q;
    rem_d         = rem_q;
    used_d        = used_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_granted_d = out_granted_q;
    out_status_d  = out_status_q;
    out_used_d    = out_used_q;
    wr_en         = 1'b0;
    wr_addr       = scan_addr;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = scan_addr;

    unique case (state_q)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(ROWS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          g_d           = '0;
          w_d           = '0;
          acc_d         = '0;
          res_granted_d = '0;
          res_status_d  = ST_OK;
          if (action_i == ACT_ALLOC) begin
            state_d = S_RD;
          end else if ((number_i == '0) && base_q) begin
            res_status_d = ST_RANGE;
            state_d      = S_RESP;
          end else begin
            rem_d   = number_i - NUM_W'(base_q);
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_q < NUM_W'(gs_eff)) begin
          state_d = S_FRD;
        end else if (g_q == gc_last) begin
          res_status_d = ST_RANGE;
          state_d      = S_RESP;
        end else begin
          rem_d = rem_q - NUM_W'(gs_eff);
          g_d   = g_q + GRP_W'(1);
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (freebits != '0) begin
          wr_en         = 1'b1;
          wr_data       = rd_data | (32'h1 << fbit);
          if (used_q != '1) used_d = used_q + NUM_W'(1);
          res_granted_d = acc_q + NUM_W'({w_q, fbit}) + NUM_W'(base_q);
          state_d       = S_RESP;
        end else if (w_q == last_w) begin
          if (g_q == gc_last) begin
            res_status_d = ST_FULL;
            state_d      = S_RESP;
          end else begin
            g_d     = g_q + GRP_W'(1);
            w_d     = '0;
            acc_d   = acc_q + NUM_W'(gs_eff);
            state_d = S_RD;
          end
        end else begin
          w_d     = w_q + WRD_W'(1);
          state_d = S_RD;
        end
      end
      S_FRD: begin
        rd_en   = 1'b1;
        rd_addr = free_addr;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        wr_addr = free_addr;
        if (rd_data[rbit]) begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~(32'h1 << rbit);
          if (used_q != '0) used_d = used_q - NUM_W'(1);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (can_load) begin
          out_valid_d   = 1'b1;
          out_granted_d = res_granted_q;
          out_status_d  = res_status_q;
          out_used_d    = used_q;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q           <= g_d;
    w_q           <= w_d;
    acc_q         <= acc_d;
    rem_q         <= rem_d;
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
    out_granted_q <= out_granted_d;
    out_status_q  <= out_status_d;
    out_used_q    <= out_used_d;
  end

  gbffa_ram #(
    .WIDTH(32),
    .DEPTH(ROWS)
  ) u_bitmap (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o  = out_valid_q;
  assign granted_o    = out_granted_q;
  assign status_o     = out_status_q;
  assign used_count_o = out_used_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_OK) || (status_o == ST_FULL) || (status_o == ST_RANGE)))
    else $error("bad status code");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (granted_o == '0))
    else $error("nonzero grant on failed request");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      ((used_q == $past(used_q) + NUM_W'(1)) || (used_q == $past(used_q) - NUM_W'(1))))
    else $error("used count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_en)
    else $error("bitmap written while idle");

endmodule
